FILE: hw/rtl/assert_macros.svh
// Assertion helpers for the RTL, included by fixed_point_alu_core.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge while reset is released.
`define ASSERT_CLK(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Check a property on every rising edge, reset included.
`define ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/falu_pkg.sv
package falu_pkg;

    localparam int DATA_W    = 32;
    localparam int CMD_W     = 4;
    localparam int FRAC_BITS = 8;
    // Dividend width: magnitude of the left operand pre-shifted by the fraction
    localparam int NUM_W     = DATA_W + FRAC_BITS;

    typedef enum logic [CMD_W-1:0] {
        OP_ADD        = 4'd0,
        OP_SUB        = 4'd1,
        OP_MUL        = 4'd2,
        OP_DIV        = 4'd3,
        OP_LT         = 4'd4,
        OP_LE         = 4'd5,
        OP_GT         = 4'd6,
        OP_GE         = 4'd7,
        OP_EQ         = 4'd8,
        OP_NE         = 4'd9,
        OP_MIN        = 4'd10,
        OP_MAX        = 4'd11,
        OP_INC        = 4'd12,
        OP_DEC        = 4'd13,
        OP_INT_TO_FIX = 4'd14,
        OP_FIX_TO_INT = 4'd15
    } op_t;

    // Sideband that rides alongside the divider stages
    typedef struct packed {
        logic              is_div;
        logic              neg;
        logic              dz;
        logic              cmp;
        logic [DATA_W-1:0] res;
    } side_t;

endpackage

FILE: hw/rtl/falu_divider.sv
module falu_divider (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic                                in_valid,
    input  falu_pkg::side_t                     in_side,
    input  logic [falu_pkg::NUM_W-1:0]          in_num,
    input  logic [falu_pkg::DATA_W-1:0]         in_den,
    output logic                                out_valid,
    output falu_pkg::side_t                     out_side,
    output logic [falu_pkg::DATA_W-1:0]         out_quot
);

    localparam int NW = falu_pkg::NUM_W;
    localparam int DW = falu_pkg::DATA_W;

    // One restoring step per stage, dividend consumed from the top bit down
    logic                  vld_reg  [NW];
    falu_pkg::side_t       side_reg [NW];
    logic [NW-1:0]         num_reg  [NW];
    logic [DW-1:0]         den_reg  [NW];
    logic [DW-1:0]         rem_reg  [NW];
    logic [DW-1:0]         quo_reg  [NW];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic              prev_vld;
        falu_pkg::side_t   prev_side;
        logic [NW-1:0]     prev_num;
        logic [DW-1:0]     prev_den;
        logic [DW-1:0]     prev_rem;
        logic [DW-1:0]     prev_quo;
        logic [DW:0]       trial;
        logic [DW:0]       diff;
        logic              qbit;

        if (k == 0) begin : g_first
            assign prev_vld  = in_valid;
            assign prev_side = in_side;
            assign prev_num  = in_num;
            assign prev_den  = in_den;
            assign prev_rem  = '0;
            assign prev_quo  = '0;
        end else begin : g_next
            assign prev_vld  = vld_reg[k-1];
            assign prev_side = side_reg[k-1];
            assign prev_num  = num_reg[k-1];
            assign prev_den  = den_reg[k-1];
            assign prev_rem  = rem_reg[k-1];
            assign prev_quo  = quo_reg[k-1];
        end

        // Trial subtract: no borrow means the quotient bit is one
        assign trial = {prev_rem, prev_num[NW-1]};
        assign diff  = trial - {1'b0, prev_den};
        assign qbit  = ~diff[DW];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= prev_vld;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[k] <= prev_side;
                num_reg[k]  <= {prev_num[NW-2:0], 1'b0};
                den_reg[k]  <= prev_den;
                rem_reg[k]  <= qbit ? diff[DW-1:0] : trial[DW-1:0];
                quo_reg[k]  <= {prev_quo[DW-2:0], qbit};
            end
        end
    end

    assign out_valid = vld_reg[NW-1];
    assign out_side  = side_reg[NW-1];
    assign out_quot  = quo_reg[NW-1];

endmodule

FILE: hw/rtl/fixed_point_alu_core.sv
// Signed fixed-point ALU, 32-bit operands with FRAC_BITS fractional bits.
// Input stream: s_tuser carries the opcode, s_tdata the two raw operands.
// Output stream: m_tdata carries the result, m_tuser the compare and
// divide-by-zero flags. Each accepted transaction gives one result, in order.
// Throughput: one transaction per cycle sustained, for every opcode, while
// the output does not stall. Every opcode takes the same registered path:
// stages A, B and C, the divider stages, then the output register. Its
// length is set by the divider, which resolves one quotient bit per pipeline
// stage over the 32 + FRAC_BITS bit dividend; other opcodes ride alongside it.
// Stall: when m_tvalid is high and m_tready low, the whole pipeline holds.
// A registered skid slot on the input catches the transaction taken in the
// stall cycle, so s_tready is a flop and drops in the next cycle; nothing is
// lost or repeated.
// Reset: aresetn (synchronous, active low) empties every stage and the skid
// slot; s_tready is high in the first cycle after reset.
// Division by zero gives result 0 with the divide_by_zero flag set.
`include "assert_macros.svh"

module fixed_point_alu_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // operand_a [31:0], operand_b [63:32]
    input  logic [3:0]  s_tuser,   // cmd [3:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // result [31:0]
    output logic [1:0]  m_tuser    // compare_true [0], divide_by_zero [1]
);

    localparam int DW = falu_pkg::DATA_W;
    localparam int NW = falu_pkg::NUM_W;
    localparam int FB = falu_pkg::FRAC_BITS;

    logic pipe_en;
    logic s_fire;

    // Skid slot
    logic                  skid_valid_reg;
    logic [3:0]            skid_cmd_reg;
    logic [DW-1:0]         skid_opa_reg;
    logic [DW-1:0]         skid_opb_reg;

    logic                  in_valid;
    logic [3:0]            in_cmd;
    logic [DW-1:0]         in_opa;
    logic [DW-1:0]         in_opb;

    // Stage A: operand register
    logic                  a_vld_reg;
    falu_pkg::op_t         a_cmd_reg;
    logic signed [DW-1:0]  a_opa_reg;
    logic signed [DW-1:0]  a_opb_reg;

    // Stage B: simple ops, multiply, divider set-up
    logic                  b_vld_reg;
    logic [DW-1:0]         b_res_reg,  b_res_next;
    logic                  b_cmp_reg,  b_cmp_next;
    logic                  b_dz_reg,   b_dz_next;
    logic                  b_mul_reg,  b_mul_next;
    logic                  b_div_reg,  b_div_next;
    logic                  b_neg_reg,  b_neg_next;
    logic signed [2*DW-1:0] b_prod_reg, b_prod_next;
    logic [NW-1:0]         b_num_reg,  b_num_next;
    logic [DW-1:0]         b_den_reg,  b_den_next;

    // Stage C: divider feed
    logic                  c_vld_reg;
    falu_pkg::side_t       c_side_reg, c_side_next;
    logic [NW-1:0]         c_num_reg;
    logic [DW-1:0]         c_den_reg;

    // Divider output
    logic                  d_valid;
    falu_pkg::side_t       d_side;
    logic [DW-1:0]         d_quot;

    // Output register
    logic                  m_valid_reg;
    logic [DW-1:0]         m_res_reg, m_res_next;
    logic                  m_cmp_reg;
    logic                  m_dz_reg;

    logic [DW-1:0]         mag_a;
    logic [DW-1:0]         mag_b;
    logic                  a_lt_b;
    logic                  a_eq_b;
    logic signed [2*DW-1:0] prod_sh;

    // Advance everything whenever the output slot is free or being drained
    assign pipe_en  = !m_valid_reg || m_tready;
    assign s_tready = !skid_valid_reg;
    assign s_fire   = s_tvalid && s_tready;

    // Take from the skid slot first, else straight from the port
    assign in_valid = skid_valid_reg || s_fire;
    assign in_cmd   = skid_valid_reg ? skid_cmd_reg : s_tuser;
    assign in_opa   = skid_valid_reg ? skid_opa_reg : s_tdata[DW-1:0];
    assign in_opb   = skid_valid_reg ? skid_opb_reg : s_tdata[2*DW-1:DW];

    // Hold a transaction that arrives while the pipeline is stalled
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            skid_valid_reg <= 1'b0;
        end else if (s_fire) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!pipe_en && s_fire) begin
            skid_cmd_reg <= s_tuser;
            skid_opa_reg <= s_tdata[DW-1:0];
            skid_opb_reg <= s_tdata[2*DW-1:DW];
        end
    end

    // Stage B logic
    assign mag_a  = a_opa_reg[DW-1] ? DW'(-a_opa_reg) : a_opa_reg;
    assign mag_b  = a_opb_reg[DW-1] ? DW'(-a_opb_reg) : a_opb_reg;
    assign a_lt_b = a_opa_reg < a_opb_reg;
    assign a_eq_b = a_opa_reg == a_opb_reg;

    always_comb begin
        b_res_next  = '0;
        b_cmp_next  = 1'b0;
        b_dz_next   = 1'b0;
        b_mul_next  = 1'b0;
        b_div_next  = 1'b0;
        b_neg_next  = a_opa_reg[DW-1] ^ a_opb_reg[DW-1];
        b_prod_next = a_opa_reg * a_opb_reg;
        b_num_next  = {mag_a, {FB{1'b0}}};
        b_den_next  = mag_b;
        case (a_cmd_reg)
            falu_pkg::OP_ADD:        b_res_next = a_opa_reg + a_opb_reg;
            falu_pkg::OP_SUB:        b_res_next = a_opa_reg - a_opb_reg;
            falu_pkg::OP_MUL:        b_mul_next = 1'b1;
            falu_pkg::OP_DIV: begin
                b_div_next = 1'b1;
                b_dz_next  = (a_opb_reg == '0);
            end
            falu_pkg::OP_LT:         b_cmp_next = a_lt_b;
            falu_pkg::OP_LE:         b_cmp_next = a_lt_b || a_eq_b;
            falu_pkg::OP_GT:         b_cmp_next = !a_lt_b && !a_eq_b;
            falu_pkg::OP_GE:         b_cmp_next = !a_lt_b;
            falu_pkg::OP_EQ:         b_cmp_next = a_eq_b;
            falu_pkg::OP_NE:         b_cmp_next = !a_eq_b;
            falu_pkg::OP_MIN:        b_res_next = a_lt_b ? a_opa_reg : a_opb_reg;
            falu_pkg::OP_MAX:        b_res_next = (!a_lt_b && !a_eq_b) ? a_opa_reg
                                                                       : a_opb_reg;
            falu_pkg::OP_INC:        b_res_next = a_opa_reg + DW'(1);
            falu_pkg::OP_DEC:        b_res_next = a_opa_reg - DW'(1);
            falu_pkg::OP_INT_TO_FIX: b_res_next = a_opa_reg << FB;
            falu_pkg::OP_FIX_TO_INT: b_res_next = a_opa_reg >>> FB;
            default:                 b_res_next = '0;
        endcase
    end

    // Stage C logic: scale the product back down
    assign prod_sh = b_prod_reg >>> FB;

    always_comb begin
        c_side_next.is_div = b_div_reg;
        c_side_next.neg    = b_neg_reg;
        c_side_next.dz     = b_dz_reg;
        c_side_next.cmp    = b_cmp_reg;
        c_side_next.res    = b_mul_reg ? prod_sh[DW-1:0] : b_res_reg;
    end

    // Advance stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg   <= 1'b0;
            b_vld_reg   <= 1'b0;
            c_vld_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            a_vld_reg   <= in_valid;
            b_vld_reg   <= a_vld_reg;
            c_vld_reg   <= b_vld_reg;
            m_valid_reg <= d_valid;
        end
    end

    // Advance stage payloads
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            a_cmd_reg  <= falu_pkg::op_t'(in_cmd);
            a_opa_reg  <= in_opa;
            a_opb_reg  <= in_opb;
            b_res_reg  <= b_res_next;
            b_cmp_reg  <= b_cmp_next;
            b_dz_reg   <= b_dz_next;
            b_mul_reg  <= b_mul_next;
            b_div_reg  <= b_div_next;
            b_neg_reg  <= b_neg_next;
            b_prod_reg <= b_prod_next;
            b_num_reg  <= b_num_next;
            b_den_reg  <= b_den_next;
            c_side_reg <= c_side_next;
            c_num_reg  <= b_num_reg;
            c_den_reg  <= b_den_reg;
            m_res_reg  <= m_res_next;
            m_cmp_reg  <= d_side.cmp;
            m_dz_reg   <= d_side.dz;
        end
    end

    falu_divider u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (c_vld_reg),
        .in_side   (c_side_reg),
        .in_num    (c_num_reg),
        .in_den    (c_den_reg),
        .out_valid (d_valid),
        .out_side  (d_side),
        .out_quot  (d_quot)
    );

    // Pass non-divide results through; apply quotient sign, drop it on a zero divisor
    always_comb begin
        if (!d_side.is_div) begin
            m_res_next = d_side.res;
        end else if (d_side.dz) begin
            m_res_next = '0;
        end else if (d_side.neg) begin
            m_res_next = DW'(-d_quot);
        end else begin
            m_res_next = d_quot;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_res_reg;
    assign m_tuser  = {m_dz_reg, m_cmp_reg};

    `ASSERT_ALWAYS(a_reset_empties_output, aclk, !aresetn |=> !m_tvalid)
    `ASSERT_CLK(a_skid_fills_on_stall, aclk, aresetn,
                $rose(skid_valid_reg) |-> $past(!pipe_en))
    `ASSERT_CLK(a_flags_exclusive, aclk, aresetn, m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    `ASSERT_CLK(a_div_zero_clears_result, aclk, aresetn,
                (m_tvalid && m_tuser[1]) |-> (m_tdata == '0))

endmodule

FILE: tb/sv/fixed_point_alu_core_tb.sv
`timescale 1ns / 1ps

module fixed_point_alu_core_tb;

    localparam int          RANDOM_OPS     = 1525;
    localparam int          TAIL_OPS       = 120;
    localparam int          LONG_HOLD      = 150;
    localparam int          HOLD_AFTER     = 400;
    localparam int          SETTLE_CYCLES  = 60;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam logic [31:0] MIN32          = 32'h8000_0000;
    localparam logic [31:0] MAX32          = 32'h7fff_ffff;

    typedef struct {
        falu_pkg::op_t cmd;
        logic [31:0]   a;
        logic [31:0]   b;
        bit            drain;
    } alu_op_t;

    typedef struct {
        logic [31:0] value;
        logic        cmp;
        logic        dz;
    } alu_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;   // operand_a [31:0], operand_b [63:32]
    logic [3:0]  s_tuser  = '0;   // cmd [3:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // result [31:0]
    logic [1:0]  m_tuser;         // compare_true [0], divide_by_zero [1]

    alu_op_t     op_queue[$];
    alu_result_t awaited[$];
    alu_op_t     cur_op;

    int  n_issued    = 0;
    int  n_checked   = 0;
    int  errors      = 0;
    int  n_div_zero  = 0;
    int  n_cmp_true  = 0;
    int  idle_cycles = 0;
    bit  quiet_tail  = 1'b0;

    fixed_point_alu_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    // Work out the result of one operation at full precision, keep the low 32 bits
    function automatic alu_result_t alu_predict(alu_op_t op);
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [63:0] wide;
        logic [63:0]        mag_a;
        logic [63:0]        mag_b;
        logic [63:0]        quot;
        alu_result_t        r;
        a = op.a;
        b = op.b;
        r.value = '0;
        r.cmp   = 1'b0;
        r.dz    = 1'b0;
        case (op.cmd)
            falu_pkg::OP_ADD: r.value = a + b;
            falu_pkg::OP_SUB: r.value = a - b;
            falu_pkg::OP_MUL: begin
                wide    = a * b;
                wide    = wide >>> falu_pkg::FRAC_BITS;
                r.value = wide[31:0];
            end
            falu_pkg::OP_DIV: begin
                if (b == 0) begin
                    r.dz = 1'b1;
                end else begin
                    wide  = a;
                    mag_a = wide[63] ? -wide : wide;
                    wide  = b;
                    mag_b = wide[63] ? -wide : wide;
                    quot  = (mag_a << falu_pkg::FRAC_BITS) / mag_b;
                    if (a[31] ^ b[31])
                        quot = -quot;
                    r.value = quot[31:0];
                end
            end
            falu_pkg::OP_LT:         r.cmp = a < b;
            falu_pkg::OP_LE:         r.cmp = a <= b;
            falu_pkg::OP_GT:         r.cmp = a > b;
            falu_pkg::OP_GE:         r.cmp = a >= b;
            falu_pkg::OP_EQ:         r.cmp = a == b;
            falu_pkg::OP_NE:         r.cmp = a != b;
            falu_pkg::OP_MIN:        r.value = (a < b) ? a : b;
            falu_pkg::OP_MAX:        r.value = (a > b) ? a : b;
            falu_pkg::OP_INC:        r.value = a + 1;
            falu_pkg::OP_DEC:        r.value = a - 1;
            falu_pkg::OP_INT_TO_FIX: r.value = a << falu_pkg::FRAC_BITS;
            default:                 r.value = a >>> falu_pkg::FRAC_BITS;
        endcase
        return r;
    endfunction

    // Mix extremes, small integers, moderate fixed-point values and full-range noise
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 4))
                    0:       return MIN32;
                    1:       return MAX32;
                    2:       return 32'd0;
                    3:       return 32'd1;
                    default: return '1;
                endcase
            end
            1, 2:    return $urandom_range(0, 4095) - 32'd2048;
            3:       return $urandom_range(0, 32'h1_ffff) - 32'h1_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_op(falu_pkg::op_t cmd, logic [31:0] a, logic [31:0] b,
                            bit drain = 1'b0);
        alu_op_t op;
        op.cmd   = cmd;
        op.a     = a;
        op.b     = b;
        op.drain = drain;
        op_queue.push_back(op);
    endtask

    // Offer queued operations, record a prediction for each accepted transaction
    always @(posedge aclk) begin : drive_ops
        bit acc;
        int outstanding;
        int gap_left;
        int gap_odds;
        int cyc;
        alu_op_t nxt;
        alu_result_t pred;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_left = 0;
            gap_odds = 20;
            cyc      = 0;
        end else begin
            acc = s_tvalid && s_tready;
            if (acc) begin
                pred = alu_predict(cur_op);
                awaited.push_back(pred);
                n_issued <= n_issued + 1;
                if (pred.dz)
                    n_div_zero++;
                if (pred.cmp)
                    n_cmp_true++;
            end
            outstanding = n_issued + int'(acc) - n_checked;

            // vary the idle density so some stretches have no gaps at all
            cyc++;
            if (cyc % 128 == 0) begin
                case ($urandom_range(0, 3))
                    0:       gap_odds = 0;
                    1:       gap_odds = 10;
                    2:       gap_odds = 25;
                    default: gap_odds = 40;
                endcase
            end

            // advance only when the current transaction has gone or none is offered
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (!quiet_tail && $urandom_range(0, 99) < gap_odds) begin
                    gap_left = $urandom_range(0, 2);
                    s_tvalid <= 1'b0;
                end else if (op_queue.size() > 0 && !(op_queue[0].drain && outstanding != 0)) begin
                    nxt = op_queue.pop_front();
                    cur_op = nxt;
                    s_tdata  <= {nxt.b, nxt.a};
                    s_tuser  <= nxt.cmd;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            quiet_tail <= (op_queue.size() < TAIL_OPS);
        end
    end

    // Compare each result with the oldest prediction and drive backpressure
    always @(posedge aclk) begin : check_results
        alu_result_t want;
        int stall_left;
        int stall_odds;
        int hold_left;
        int cyc;
        bit hold_done;
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
            stall_odds = 20;
            hold_left  = 0;
            hold_done  = 1'b0;
            cyc        = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (awaited.size() == 0) begin
                    errors++;
                    $display("%0t: result with nothing pending, actual data %h flags %b",
                             $time, m_tdata, m_tuser);
                end else begin
                    want = awaited.pop_front();
                    n_checked <= n_checked + 1;
                    if (m_tdata !== want.value) begin
                        errors++;
                        $display("%0t: result mismatch, expected %h actual %h",
                                 $time, want.value, m_tdata);
                    end
                    if (m_tuser[0] !== want.cmp) begin
                        errors++;
                        $display("%0t: compare_true mismatch, expected %b actual %b",
                                 $time, want.cmp, m_tuser[0]);
                    end
                    if (m_tuser[1] !== want.dz) begin
                        errors++;
                        $display("%0t: divide_by_zero mismatch, expected %b actual %b",
                                 $time, want.dz, m_tuser[1]);
                    end
                end
            end

            cyc++;
            if (cyc % 128 == 64) begin
                case ($urandom_range(0, 3))
                    0:       stall_odds = 0;
                    1:       stall_odds = 10;
                    2:       stall_odds = 25;
                    default: stall_odds = 40;
                endcase
            end

            // hold off once for long enough to fill the pipeline and stall the input
            if (!hold_done && n_checked >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end

            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 99) < stall_odds) begin
                stall_left = $urandom_range(0, 2);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // End the run if no transaction moves on either side for too long
    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: timeout, no transaction for %0d cycles, %0d results pending",
                     $time, idle_cycles, awaited.size());
            $display("** fixed_point_alu_core: FAILED **");
            $finish;
        end
    end

    initial begin : stimulus
        logic [31:0] a;
        logic [31:0] b;
        int r;

        // directed: wrap, overflow, rounding and divide-by-zero corners
        queue_op(falu_pkg::OP_ADD, MAX32, 32'd1);
        queue_op(falu_pkg::OP_SUB, MIN32, 32'd1);
        queue_op(falu_pkg::OP_MUL, MAX32, MAX32);
        queue_op(falu_pkg::OP_MUL, MIN32, MIN32);
        queue_op(falu_pkg::OP_MUL, MIN32, '1);
        queue_op(falu_pkg::OP_MUL, 32'hffff_ff00, 32'h0000_0080);
        queue_op(falu_pkg::OP_DIV, MIN32, '1);
        queue_op(falu_pkg::OP_DIV, 32'h0000_1234, 32'd0);
        queue_op(falu_pkg::OP_DIV, MAX32, 32'd1);
        queue_op(falu_pkg::OP_DIV, '1, 32'd3);
        queue_op(falu_pkg::OP_DIV, 32'h0000_0300, 32'hffff_fe00);
        queue_op(falu_pkg::OP_LT, MIN32, MAX32);
        queue_op(falu_pkg::OP_LE, MAX32, MAX32);
        queue_op(falu_pkg::OP_GT, MIN32, MAX32);
        queue_op(falu_pkg::OP_GE, MIN32, MIN32);
        queue_op(falu_pkg::OP_EQ, 32'd5, 32'd5);
        queue_op(falu_pkg::OP_NE, MIN32, MAX32);
        queue_op(falu_pkg::OP_MIN, MAX32, MIN32);
        queue_op(falu_pkg::OP_MAX, MIN32, MAX32);
        queue_op(falu_pkg::OP_MIN, 32'd7, 32'd7);
        queue_op(falu_pkg::OP_INC, MAX32, 32'd0);
        queue_op(falu_pkg::OP_DEC, MIN32, MAX32);
        queue_op(falu_pkg::OP_INT_TO_FIX, 32'h00ff_ffff, '1);
        queue_op(falu_pkg::OP_FIX_TO_INT, '1, 32'd0);
        queue_op(falu_pkg::OP_FIX_TO_INT, MIN32, 32'd0);

        // random: every opcode, mixed operands, two points where the sender drains
        for (int i = 0; i < RANDOM_OPS; i++) begin
            a = pick_operand();
            b = pick_operand();
            r = $urandom_range(0, 9);
            if (r == 0)
                b = a;
            else if (r == 1)
                b = 32'd0;
            queue_op(falu_pkg::op_t'($urandom_range(0, 15)), a, b,
                     (i == 500 || i == 1000));
        end

        // reset, then release it once
        aresetn <= 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // wait for the queue to empty and every prediction to be met
        @(negedge aclk);
        while (op_queue.size() != 0 || s_tvalid || n_checked != n_issued || awaited.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);

        if (awaited.size() != 0) begin
            errors++;
            $display("%0t: %0d predictions never matched by a result", $time, awaited.size());
        end

        $display("Covered %0d operations over all opcodes, with long output stall and drains.",
                 n_issued);
        $display("Checked %0d results: %0d divides by zero, %0d true compares, %0d errors.",
                 n_checked, n_div_zero, n_cmp_true, errors);
        if (errors == 0)
            $display("** fixed_point_alu_core: PASSED **");
        else
            $display("** fixed_point_alu_core: FAILED **");
        $finish;
    end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/falu_pkg.sv
hw/rtl/falu_divider.sv
hw/rtl/fixed_point_alu_core.sv
tb/sv/fixed_point_alu_core_tb.sv
